// ----- hdl/refpfa_pkg.sv -----
package refpfa_pkg;

    localparam int FRAME_BITS  = 9;
    localparam int KIND_BITS   = 3;
    localparam int STATUS_BITS = 3;
    localparam int DIV_SHIFT   = 16;

    localparam logic [KIND_BITS-1:0] KIND_INIT    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ALLOC   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_RELEASE = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_COW     = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_ADDREF  = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_INPLACE  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_COPY     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_OOM      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_COUNTERR = 3'd5;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FRAME_BITS-1:0] frame;
        logic                  entry_valid;
    } req_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0]  frame_out;
        logic [STATUS_BITS-1:0] status;
    } res_t;

    typedef enum logic [1:0] {
        FSRC_NONE,
        FSRC_REQ,
        FSRC_NEW
    } fsrc_t;

    typedef struct packed {
        logic                   load;
        logic                   clr_step;
        logic                   clr_fill;
        logic                   cnt_wr_dec;
        logic                   cnt_wr_inc;
        logic                   cnt_wr_one;
        logic                   div1;
        logic                   div2;
        logic                   scan_init;
        logic                   scan_step;
        logic                   bmp_scan;
        logic                   take_found;
        logic                   bmp_wr_alloc;
        logic                   bmp_wr_free;
        logic                   finish;
        logic [STATUS_BITS-1:0] res_status;
        fsrc_t                  res_src;
    } cmd_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 entry_valid;
        logic                 frame_oob;
        logic                 cnt_zero;
        logic                 cnt_one;
        logic                 cnt_max;
        logic                 clr_last;
        logic                 scan_hit;
        logic                 scan_last;
    } stat_t;

endpackage

// ----- hdl/refpfa_ram.sv -----
module refpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/refpfa_ctrl.sv -----
module refpfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output refpfa_pkg::cmd_t  cmd,
    input  refpfa_pkg::stat_t st
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_DIV1,
        S_DIV2,
        S_BMP_RD,
        S_BMP_WR,
        S_SCAN_START,
        S_SCAN,
        S_COW_DEC,
        S_ALLOC_WR
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             init_reg;
    logic             init_next;
    logic             done_reg;
    refpfa_pkg::cmd_t cmd_c;

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        cmd_c      = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd_c.clr_step = 1'b1;
                cmd_c.clr_fill = init_reg;
                if (st.clr_last)
                begin
                    cmd_c.finish     = init_reg;
                    cmd_c.res_status = refpfa_pkg::ST_OK;
                    cmd_c.res_src    = refpfa_pkg::FSRC_NONE;
                    init_next        = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_c.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.kind) inside
                    refpfa_pkg::KIND_INIT:
                    begin
                        init_next  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    refpfa_pkg::KIND_ALLOC:
                    begin
                        state_next = S_SCAN_START;
                    end
                    refpfa_pkg::KIND_RELEASE:
                    begin
                        if (!st.entry_valid)
                        begin
                            cmd_c.finish     = 1'b1;
                            cmd_c.res_status = refpfa_pkg::ST_IGNORED;
                            cmd_c.res_src    = refpfa_pkg::FSRC_NONE;
                            state_next       = S_IDLE;
                        end
                        else if (st.frame_oob)
                        begin
                            cmd_c.finish     = 1'b1;
                            cmd_c.res_status = refpfa_pkg::ST_COUNTERR;
                            cmd_c.res_src    = refpfa_pkg::FSRC_REQ;
                            state_next       = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    refpfa_pkg::KIND_COW,
                    refpfa_pkg::KIND_ADDREF:
                    begin
                        if (st.frame_oob)
                        begin
                            cmd_c.finish     = 1'b1;
                            cmd_c.res_status = refpfa_pkg::ST_COUNTERR;
                            cmd_c.res_src    = refpfa_pkg::FSRC_REQ;
                            state_next       = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        cmd_c.finish     = 1'b1;
                        cmd_c.res_status = refpfa_pkg::ST_IGNORED;
                        cmd_c.res_src    = refpfa_pkg::FSRC_NONE;
                        state_next       = S_IDLE;
                    end
                endcase
            end
            S_CHECK:
            begin
                unique case (st.kind)
                    refpfa_pkg::KIND_RELEASE:
                    begin
                        if (st.cnt_zero)
                        begin
                            cmd_c.finish     = 1'b1;
                            cmd_c.res_status = refpfa_pkg::ST_COUNTERR;
                            cmd_c.res_src    = refpfa_pkg::FSRC_REQ;
                            state_next       = S_IDLE;
                        end
                        else
                        begin
                            cmd_c.cnt_wr_dec = 1'b1;
                            if (st.cnt_one)
                            begin
                                state_next = S_DIV1;
                            end
                            else
                            begin
                                cmd_c.finish     = 1'b1;
                                cmd_c.res_status = refpfa_pkg::ST_OK;
                                cmd_c.res_src    = refpfa_pkg::FSRC_REQ;
                                state_next       = S_IDLE;
                            end
                        end
                    end
                    refpfa_pkg::KIND_COW:
                    begin
                        if (st.cnt_zero || st.cnt_one)
                        begin
                            cmd_c.finish     = 1'b1;
                            cmd_c.res_status = st.cnt_zero ? refpfa_pkg::ST_COUNTERR
                                                           : refpfa_pkg::ST_INPLACE;
                            cmd_c.res_src    = refpfa_pkg::FSRC_REQ;
                            state_next       = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN_START;
                        end
                    end
                    refpfa_pkg::KIND_ADDREF:
                    begin
                        cmd_c.cnt_wr_inc = !st.cnt_max;
                        cmd_c.finish     = 1'b1;
                        cmd_c.res_status = st.cnt_max ? refpfa_pkg::ST_COUNTERR
                                                      : refpfa_pkg::ST_OK;
                        cmd_c.res_src    = refpfa_pkg::FSRC_REQ;
                        state_next       = S_IDLE;
                    end
                    default:
                    begin
                        cmd_c.finish     = 1'b1;
                        cmd_c.res_status = refpfa_pkg::ST_IGNORED;
                        cmd_c.res_src    = refpfa_pkg::FSRC_NONE;
                        state_next       = S_IDLE;
                    end
                endcase
            end
            S_DIV1:
            begin
                cmd_c.div1 = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd_c.div2 = 1'b1;
                state_next = S_BMP_RD;
            end
            S_BMP_RD:
            begin
                state_next = S_BMP_WR;
            end
            S_BMP_WR:
            begin
                cmd_c.bmp_wr_free = 1'b1;
                cmd_c.finish      = 1'b1;
                cmd_c.res_status  = refpfa_pkg::ST_OK;
                cmd_c.res_src     = refpfa_pkg::FSRC_REQ;
                state_next        = S_IDLE;
            end
            S_SCAN_START:
            begin
                cmd_c.scan_init = 1'b1;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                cmd_c.bmp_scan = 1'b1;
                if (st.scan_hit)
                begin
                    cmd_c.take_found = 1'b1;
                    state_next = (st.kind == refpfa_pkg::KIND_COW) ? S_COW_DEC : S_ALLOC_WR;
                end
                else if (st.scan_last)
                begin
                    cmd_c.finish     = 1'b1;
                    cmd_c.res_status = refpfa_pkg::ST_OOM;
                    cmd_c.res_src    = refpfa_pkg::FSRC_NONE;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cmd_c.scan_step = 1'b1;
                end
            end
            S_COW_DEC:
            begin
                cmd_c.cnt_wr_dec = 1'b1;
                state_next       = S_ALLOC_WR;
            end
            S_ALLOC_WR:
            begin
                cmd_c.bmp_wr_alloc = 1'b1;
                cmd_c.cnt_wr_one   = 1'b1;
                cmd_c.finish       = 1'b1;
                cmd_c.res_status   = (st.kind == refpfa_pkg::KIND_COW) ? refpfa_pkg::ST_COPY
                                                                       : refpfa_pkg::ST_OK;
                cmd_c.res_src      = refpfa_pkg::FSRC_NEW;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            init_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            done_reg  <= cmd_c.finish;
        end
    end

    assign cmd  = cmd_c;
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ----- hdl/refpfa_datapath.sv -----
module refpfa_datapath #(
    parameter int NUM_FRAMES    = 512,
    parameter int MAP_WORD_BITS = 32,
    parameter int COUNT_WIDTH   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  refpfa_pkg::req_t                    req,
    input  logic                                cfg_wr_en,
    input  logic [refpfa_pkg::FRAME_BITS-1:0]   cfg_wr_data,
    input  refpfa_pkg::cmd_t                    cmd,
    output refpfa_pkg::stat_t                   st,
    output refpfa_pkg::res_t                    result
);

    localparam int MAP_WORDS = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int FW        = $clog2(NUM_FRAMES);
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_WORD_BITS);
    localparam int NW        = FW + 7;
    localparam int IW        = $clog2(MAP_WORDS * MAP_WORD_BITS) + 1;
    localparam int FB        = refpfa_pkg::FRAME_BITS;
    localparam int PW        = FB + refpfa_pkg::DIV_SHIFT;
    localparam int DW        = FB + 7;
    localparam int RECIP     = (1 << refpfa_pkg::DIV_SHIFT) / MAP_WORD_BITS;

    refpfa_pkg::req_t         req_reg;
    logic [FB-1:0]            os_last_reg;
    logic [FW-1:0]            clr_idx_reg;
    logic [WAW-1:0]           scan_addr_reg;
    logic [WAW-1:0]           data_idx_reg;
    logic [FB-1:0]            q0_reg;
    logic [WAW-1:0]           word_reg;
    logic [BW-1:0]            bit_reg;
    logic [WAW-1:0]           found_idx_reg;
    logic [MAP_WORD_BITS-1:0] found_word_reg;
    logic [FW-1:0]            nf_reg;
    refpfa_pkg::res_t         res_reg;

    logic [FW-1:0]            frame_idx;
    logic [COUNT_WIDTH-1:0]   cnt_rdata;
    logic                     cnt_we;
    logic [FW-1:0]            cnt_waddr;
    logic [COUNT_WIDTH-1:0]   cnt_wdata;
    logic [MAP_WORD_BITS-1:0] bmp_rdata;
    logic [WAW-1:0]           bmp_raddr;
    logic                     bmp_we;
    logic [WAW-1:0]           bmp_waddr;
    logic [MAP_WORD_BITS-1:0] bmp_wdata;
    logic [MAP_WORD_BITS-1:0] init_word;
    logic [BW-1:0]            low_pos;
    logic [NW-1:0]            nf_wide;
    logic [PW-1:0]            prod;
    logic [DW-1:0]            qw_wide;
    logic [FB-1:0]            r0;
    logic                     corr;
    logic [WAW-1:0]           word_next;
    logic [BW-1:0]            bit_next;
    logic [FB-1:0]            frame_out_next;

    function automatic logic [BW-1:0] low_bit(input logic [MAP_WORD_BITS-1:0] w);
        logic [BW-1:0] p;
        p = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                p = BW'(i);
            end
        end
        return p;
    endfunction

    assign frame_idx = FW'(req_reg.frame);

    refpfa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_FRAMES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (frame_idx),
        .rdata (cnt_rdata)
    );

    refpfa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bmp_we),
        .waddr (bmp_waddr),
        .wdata (bmp_wdata),
        .raddr (bmp_raddr),
        .rdata (bmp_rdata)
    );

    // A frame is free after init when it lies above the OS image and inside the frame range.
    always_comb
    begin
        logic [IW-1:0] f;
        init_word = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++)
        begin
            f = IW'(clr_idx_reg[WAW-1:0]) * IW'(MAP_WORD_BITS) + IW'(b);
            init_word[b] = cmd.clr_fill && (f > IW'(os_last_reg)) && (f < IW'(NUM_FRAMES));
        end
    end

    always_comb
    begin
        cnt_we    = cmd.clr_step | cmd.cnt_wr_dec | cmd.cnt_wr_inc | cmd.cnt_wr_one;
        cnt_waddr = frame_idx;
        cnt_wdata = cnt_rdata - COUNT_WIDTH'(1);
        if (cmd.clr_step)
        begin
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end
        else if (cmd.cnt_wr_one)
        begin
            cnt_waddr = nf_reg;
            cnt_wdata = COUNT_WIDTH'(1);
        end
        else if (cmd.cnt_wr_inc)
        begin
            cnt_wdata = cnt_rdata + COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        bmp_we    = 1'b0;
        bmp_waddr = word_reg;
        bmp_wdata = bmp_rdata | (MAP_WORD_BITS'(1) << bit_reg);
        if (cmd.clr_step)
        begin
            bmp_we    = (32'(clr_idx_reg) < MAP_WORDS);
            bmp_waddr = clr_idx_reg[WAW-1:0];
            bmp_wdata = init_word;
        end
        else if (cmd.bmp_wr_alloc)
        begin
            bmp_we    = 1'b1;
            bmp_waddr = found_idx_reg;
            bmp_wdata = found_word_reg;
        end
        else if (cmd.bmp_wr_free)
        begin
            bmp_we = 1'b1;
        end
    end

    assign bmp_raddr = cmd.scan_init ? '0 : (cmd.bmp_scan ? scan_addr_reg : word_reg);

    assign low_pos = low_bit(bmp_rdata);
    assign nf_wide = NW'(data_idx_reg) * NW'(MAP_WORD_BITS) + NW'(low_pos);

    // Frame to word and bit by reciprocal multiply, corrected by one compare and subtract.
    assign prod      = PW'(req_reg.frame) * PW'(RECIP);
    assign qw_wide   = DW'(q0_reg) * DW'(MAP_WORD_BITS);
    assign r0        = FB'(DW'(req_reg.frame) - qw_wide);
    assign corr      = (DW'(r0) >= DW'(MAP_WORD_BITS));
    assign word_next = corr ? WAW'(q0_reg + FB'(1)) : WAW'(q0_reg);
    assign bit_next  = corr ? BW'(r0 - FB'(MAP_WORD_BITS)) : BW'(r0);

    always_comb
    begin
        case (cmd.res_src)
            refpfa_pkg::FSRC_REQ: frame_out_next = req_reg.frame;
            refpfa_pkg::FSRC_NEW: frame_out_next = FB'(nf_reg);
            default:              frame_out_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            os_last_reg   <= '0;
            clr_idx_reg   <= '0;
            scan_addr_reg <= '0;
            data_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                os_last_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_idx_reg <= (clr_idx_reg == FW'(NUM_FRAMES - 1)) ? '0
                                                                     : clr_idx_reg + FW'(1);
            end
            if (cmd.scan_init)
            begin
                scan_addr_reg <= (MAP_WORDS > 1) ? WAW'(1) : '0;
                data_idx_reg  <= '0;
            end
            else if (cmd.scan_step)
            begin
                data_idx_reg <= scan_addr_reg;
                if (scan_addr_reg != WAW'(MAP_WORDS - 1))
                begin
                    scan_addr_reg <= scan_addr_reg + WAW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.div1)
        begin
            q0_reg <= FB'(prod >> refpfa_pkg::DIV_SHIFT);
        end
        if (cmd.div2)
        begin
            word_reg <= word_next;
            bit_reg  <= bit_next;
        end
        if (cmd.take_found)
        begin
            found_idx_reg  <= data_idx_reg;
            found_word_reg <= bmp_rdata & ~(MAP_WORD_BITS'(1) << low_pos);
            nf_reg         <= FW'(nf_wide);
        end
        if (cmd.finish)
        begin
            res_reg.frame_out <= frame_out_next;
            res_reg.status    <= cmd.res_status;
        end
    end

    assign st.kind        = req_reg.kind;
    assign st.entry_valid = req_reg.entry_valid;
    assign st.frame_oob   = (32'(req_reg.frame) >= NUM_FRAMES);
    assign st.cnt_zero    = (cnt_rdata == '0);
    assign st.cnt_one     = (cnt_rdata == COUNT_WIDTH'(1));
    assign st.cnt_max     = &cnt_rdata;
    assign st.clr_last    = (clr_idx_reg == FW'(NUM_FRAMES - 1));
    assign st.scan_hit    = (bmp_rdata != '0);
    assign st.scan_last   = (data_idx_reg == WAW'(MAP_WORDS - 1));

    assign result = res_reg;

endmodule

// ----- hdl/refcounted_page_frame_allocator_unit.sv -----
// Page-frame allocator with a free bitmap and a reference count per frame. A request is
// taken when start is high and busy is low; its result shows on result for exactly one
// cycle with done high, in the first cycle that busy is low again, and cannot be stalled.
// Busy time is set by the bitmap and count memories, which give one registered read a
// cycle: add reference, an in-place copy-on-write and a release that keeps the frame pass
// decode and check; a freeing release adds the divide steps, a bitmap read and a write;
// alloc (after decode) and a copying copy-on-write (after check) scan up to the bitmap
// word with the lowest free frame, one word per cycle, then write the new frame (a copy
// decrements the old count first); out of memory ends after reading all
// ceil(NUM_FRAMES / MAP_WORD_BITS) words. The clearing pass after reset sweeps the count
// memory one entry per cycle, busy high throughout; init repeats it after its decode state.
module refcounted_page_frame_allocator_unit #(
    parameter int NUM_FRAMES    = 512,
    parameter int MAP_WORD_BITS = 32,
    parameter int COUNT_WIDTH   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  refpfa_pkg::req_t                  req,
    output logic                              done,
    output refpfa_pkg::res_t                  result,
    input  logic                              cfg_wr_en,
    input  logic [refpfa_pkg::FRAME_BITS-1:0] cfg_wr_data
);

    refpfa_pkg::cmd_t  cmd;
    refpfa_pkg::stat_t st;

    refpfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .st    (st)
    );

    refpfa_datapath #(
        .NUM_FRAMES    (NUM_FRAMES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st),
        .result      (result)
    );

endmodule

// ----- hdl/refpfa_checker.sv -----
module refpfa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input refpfa_pkg::res_t result
);

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request transfer");

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the block is still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_no_frame_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == refpfa_pkg::ST_OOM ||
                  result.status == refpfa_pkg::ST_IGNORED)) |-> (result.frame_out == '0))
        else $error("frame reported with an out-of-memory or ignored status");

endmodule

bind refcounted_page_frame_allocator_unit refpfa_checker u_refpfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- bench/tb_refcounted_page_frame_allocator_unit.sv -----
module tb_refcounted_page_frame_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = 512;
    localparam int COUNT_WIDTH = 8;
    localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int FRAME_BITS = refpfa_pkg::FRAME_BITS;
    localparam int KIND_BITS = refpfa_pkg::KIND_BITS;
    localparam logic [KIND_BITS-1:0] KIND_LAST = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    refpfa_pkg::req_t req = '0;
    logic done;
    refpfa_pkg::res_t result;
    logic cfg_wr_en = 1'b0;
    logic [FRAME_BITS-1:0] cfg_wr_data = '0;

    refpfa_pkg::req_t pending_reqs[$];
    refpfa_pkg::res_t awaited_replies[$];

    // Shadow copy of the allocator state: one bit per frame, 1 = free.
    bit [NUM_FRAMES-1:0] free_map;
    bit [COUNT_WIDTH-1:0] ref_cnt[NUM_FRAMES];
    bit [FRAME_BITS-1:0] os_last;

    int gap_left = 0;
    bit gaps_on = 1'b1;
    int mismatches = 0;
    int cycle_count = 0;

    refcounted_page_frame_allocator_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5ns clk = ~clk;

    function automatic int lowest_free();
        int f;
        for (f = 0; f < NUM_FRAMES; f++)
            if (free_map[f])
                return f;
        return -1;
    endfunction

    function automatic refpfa_pkg::res_t serve_request(refpfa_pkg::req_t r);
        refpfa_pkg::res_t rs;
        int f;
        int nf;
        rs.frame_out = '0;
        rs.status = refpfa_pkg::ST_OK;
        case (r.kind)
            refpfa_pkg::KIND_INIT:
            begin
                for (f = 0; f < NUM_FRAMES; f++)
                begin
                    ref_cnt[f] = '0;
                    free_map[f] = (f > os_last);
                end
            end
            refpfa_pkg::KIND_ALLOC:
            begin
                nf = lowest_free();
                if (nf < 0)
                    rs.status = refpfa_pkg::ST_OOM;
                else
                begin
                    free_map[nf] = 1'b0;
                    ref_cnt[nf] = COUNT_WIDTH'(1);
                    rs.frame_out = FRAME_BITS'(nf);
                end
            end
            refpfa_pkg::KIND_RELEASE:
            begin
                if (!r.entry_valid)
                    rs.status = refpfa_pkg::ST_IGNORED;
                else
                begin
                    rs.frame_out = r.frame;
                    if (ref_cnt[r.frame] == 0)
                        rs.status = refpfa_pkg::ST_COUNTERR;
                    else
                    begin
                        ref_cnt[r.frame]--;
                        if (ref_cnt[r.frame] == 0)
                            free_map[r.frame] = 1'b1;
                    end
                end
            end
            refpfa_pkg::KIND_COW:
            begin
                rs.frame_out = r.frame;
                if (ref_cnt[r.frame] == 0)
                    rs.status = refpfa_pkg::ST_COUNTERR;
                else if (ref_cnt[r.frame] == 1)
                    rs.status = refpfa_pkg::ST_INPLACE;
                else
                begin
                    nf = lowest_free();
                    if (nf < 0)
                    begin
                        rs.status = refpfa_pkg::ST_OOM;
                        rs.frame_out = '0;
                    end
                    else
                    begin
                        ref_cnt[r.frame]--;
                        free_map[nf] = 1'b0;
                        ref_cnt[nf] = COUNT_WIDTH'(1);
                        rs.frame_out = FRAME_BITS'(nf);
                        rs.status = refpfa_pkg::ST_COPY;
                    end
                end
            end
            refpfa_pkg::KIND_ADDREF:
            begin
                rs.frame_out = r.frame;
                if (ref_cnt[r.frame] == COUNT_MAX)
                    rs.status = refpfa_pkg::ST_COUNTERR;
                else
                    ref_cnt[r.frame]++;
            end
            default:
                rs.status = refpfa_pkg::ST_IGNORED;
        endcase
        return rs;
    endfunction

    // Picks a frame that currently holds references, so that most requests hit live pages.
    function automatic logic [FRAME_BITS-1:0] held_frame(logic [FRAME_BITS-1:0] fallback);
        int base;
        int i;
        int f;
        base = $urandom_range(0, NUM_FRAMES - 1);
        for (i = 0; i < NUM_FRAMES; i++)
        begin
            f = (base + i) % NUM_FRAMES;
            if (ref_cnt[f] != 0)
                return FRAME_BITS'(f);
        end
        return fallback;
    endfunction

    function automatic refpfa_pkg::req_t random_req();
        refpfa_pkg::req_t r;
        int pick;
        r.frame = FRAME_BITS'($urandom_range(0, NUM_FRAMES - 1));
        r.entry_valid = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.kind = refpfa_pkg::KIND_INIT;
        else if (pick < 34)
            r.kind = refpfa_pkg::KIND_ALLOC;
        else if (pick < 58)
            r.kind = refpfa_pkg::KIND_RELEASE;
        else if (pick < 78)
            r.kind = refpfa_pkg::KIND_COW;
        else if (pick < 96)
            r.kind = refpfa_pkg::KIND_ADDREF;
        else
            r.kind = KIND_BITS'($urandom_range(refpfa_pkg::KIND_ADDREF + 1, KIND_LAST));
        if ((r.kind == refpfa_pkg::KIND_RELEASE || r.kind == refpfa_pkg::KIND_COW ||
             r.kind == refpfa_pkg::KIND_ADDREF) && $urandom_range(0, 3) != 0)
            r.frame = held_frame(r.frame);
        return r;
    endfunction

    task automatic queue_req(input logic [KIND_BITS-1:0] k, input int f, input bit v);
        refpfa_pkg::req_t r;
        r.kind = k;
        r.frame = FRAME_BITS'(f);
        r.entry_valid = v;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || awaited_replies.size() != 0 || busy);
    endtask

    task automatic write_os_last(input logic [FRAME_BITS-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        os_last = v;
    endtask

    task automatic run_random(input int count);
        refpfa_pkg::req_t r;
        int n;
        n = 0;
        while (n < count)
        begin
            @(posedge clk);
            if (pending_reqs.size() < 2)
            begin
                r = random_req();
                pending_reqs.push_back(r);
                if (r.kind <= refpfa_pkg::KIND_ADDREF &&
                    !(r.kind == refpfa_pkg::KIND_RELEASE && !r.entry_valid))
                    n++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            awaited_replies.push_back(serve_request(pending_reqs.pop_front()));
            if (gaps_on && $urandom_range(0, 2) == 0)
                gap_left = $urandom_range(1, 13);
        end
        if (gap_left != 0)
        begin
            gap_left--;
            start <= 1'b0;
        end
        else if (pending_reqs.size() != 0)
        begin
            start <= 1'b1;
            req <= pending_reqs[0];
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected result transfer: frame_out %0d status %0d",
                       result.frame_out, result.status);
                mismatches++;
            end
            else
            begin
                if (result.frame_out !== awaited_replies[0].frame_out)
                begin
                    $error("frame_out mismatch: expected %0d, actual %0d",
                           awaited_replies[0].frame_out, result.frame_out);
                    mismatches++;
                end
                if (result.status !== awaited_replies[0].status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           awaited_replies[0].status, result.status);
                    mismatches++;
                end
                void'(awaited_replies.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL refcounted_page_frame_allocator_unit");
            $finish;
        end
    end

    initial
    begin
        int i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Nothing is free before the first init.
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_RELEASE, NUM_FRAMES - 1, 1'b0);
        queue_req(refpfa_pkg::KIND_RELEASE, 0, 1'b1);
        queue_req(refpfa_pkg::KIND_COW, 5, 1'b1);
        queue_req(refpfa_pkg::KIND_ADDREF, NUM_FRAMES - 1, 1'b1);
        queue_req(refpfa_pkg::KIND_RELEASE, NUM_FRAMES - 1, 1'b1);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        queue_req(KIND_BITS'(refpfa_pkg::KIND_ADDREF + 1), NUM_FRAMES - 1, 1'b1);
        queue_req(KIND_BITS'(refpfa_pkg::KIND_ADDREF + 2), 0, 1'b1);
        queue_req(KIND_LAST, 0, 1'b0);
        wait_drained();

        write_os_last('1);
        queue_req(refpfa_pkg::KIND_INIT, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        wait_drained();

        write_os_last(FRAME_BITS'(NUM_FRAMES - 3));
        queue_req(refpfa_pkg::KIND_INIT, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_ADDREF, NUM_FRAMES - 2, 1'b1);
        queue_req(refpfa_pkg::KIND_COW, NUM_FRAMES - 2, 1'b1);
        queue_req(refpfa_pkg::KIND_COW, NUM_FRAMES - 1, 1'b1);
        queue_req(refpfa_pkg::KIND_RELEASE, NUM_FRAMES - 1, 1'b1);
        queue_req(refpfa_pkg::KIND_COW, NUM_FRAMES - 2, 1'b1);
        queue_req(refpfa_pkg::KIND_RELEASE, NUM_FRAMES - 2, 1'b1);
        queue_req(refpfa_pkg::KIND_ADDREF, NUM_FRAMES - 2, 1'b1);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_RELEASE, 0, 1'b1);
        wait_drained();

        write_os_last(FRAME_BITS'($urandom_range(0, NUM_FRAMES - 1)));
        queue_req(refpfa_pkg::KIND_INIT, 0, 1'b0);
        run_random(150);
        wait_drained();

        // Drive one frame's count into saturation, then split it with a fault.
        write_os_last('0);
        queue_req(refpfa_pkg::KIND_INIT, 0, 1'b0);
        queue_req(refpfa_pkg::KIND_ALLOC, 0, 1'b0);
        for (i = 0; i < COUNT_MAX + 1; i++)
            queue_req(refpfa_pkg::KIND_ADDREF, 1, 1'($urandom_range(0, 1)));
        queue_req(refpfa_pkg::KIND_COW, 1, 1'b1);
        wait_drained();

        write_os_last(FRAME_BITS'(NUM_FRAMES - 22));
        queue_req(refpfa_pkg::KIND_INIT, 0, 1'b0);
        run_random(120);
        wait_drained();

        gaps_on = 1'b0;
        write_os_last(FRAME_BITS'($urandom_range(0, NUM_FRAMES - 1)));
        queue_req(refpfa_pkg::KIND_INIT, 0, 1'b0);
        run_random(120);
        wait_drained();

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS refcounted_page_frame_allocator_unit");
        else
            $display("FAIL refcounted_page_frame_allocator_unit");
        $finish;
    end

endmodule
